// ===== src/scrc_pkg.sv =====
`timescale 1ns / 1ps
// scrc_pkg: shared types, constants and the bytewise crc-64 update
// used by the settings crc64 check block; no dependencies
package scrc_pkg;

  localparam int unsigned CrcW     = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned MDataW   = 72;

  localparam logic [CrcW-1:0] CrcPoly      = 64'hC96C5795D7870F42;
  localparam logic [CrcW-1:0] CrcInitReset = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CrcW-1:0] EmptyStored  = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [CfgIdxW-1:0] CFG_CRC_INIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_STORED   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_EMPTY    = 2'd0,
    VERDICT_MISMATCH = 2'd1,
    VERDICT_MATCH    = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [CrcW-1:0] crc;
    verdict_e        verdict;
  } scrc_res_t;

  // reflected update: xor byte into low end, then eight shift rounds
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/settings_crc64_check_top.sv =====
`timescale 1ns / 1ps
// settings_crc64_check_top: reflected crc-64 check over a settings byte stream
// depends on scrc_pkg, scrc_core, scrc_out
//
// usage:
//   s_axis carries one settings byte per transaction in tdata, tlast marks
//   the final byte of a run. m_axis gives one transaction per run: tdata
//   holds the crc over the run (poly 0xC96C5795D7870F42, no final xor) and
//   a verdict against the stored checksum (0 nothing stored, 1 mismatch,
//   2 match). the cfg channel writes index 0 (crc init value) or index 1
//   (stored checksum); cfg_ready_o is always high. write only while idle.
//   throughput: one byte per cycle while no last byte is held up; the eight
//   crc rounds of a byte are one xor network between the input register and
//   the result register. a last byte waits in the input register until the
//   result register takes its crc and verdict; m_axis_tvalid is its flag.
//   reset: init value 0xFFFFFFFF, stored checksum all ones, no run open,
//   both pipeline registers empty.
//   stall: the result register holds while m_axis_tready is low; bytes
//   that are not last keep flowing, a last byte waits in the input register
//   and s_axis_tready drops until the result register frees up.
module settings_crc64_check_top import scrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [MDataW-1:0]  m_axis_tdata,   // [63:0] computed_checksum,
                                             // [65:64] verdict, [71:66] zero
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CrcW-1:0]    cfg_data_i
);

  logic [CrcW-1:0] crc_init_q;
  logic [CrcW-1:0] stored_q;
  logic            res_valid;
  logic            res_ready;
  scrc_res_t       res;
  scrc_res_t       out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= CrcInitReset;
      stored_q   <= EmptyStored;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CRC_INIT: crc_init_q <= cfg_data_i;
        CFG_STORED:   stored_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .crc_init_i  (crc_init_q),
    .stored_i    (stored_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  scrc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {{(MDataW-CrcW-2){1'b0}}, out.verdict, out.crc};

`ifndef SYNTHESIS
  // input side only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a pending result");

  // a match verdict carries exactly the stored checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.verdict == VERDICT_MATCH) |-> (res.crc == stored_q))
    else $error("match verdict with differing checksum");

  // a result taken by the result register (empty or draining) lands on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("result lost between core and output register");
`endif

endmodule

// ===== src/scrc_core.sv =====
`timescale 1ns / 1ps
// scrc_core: input register, running crc state, crc update and verdict
// depends on scrc_pkg
module scrc_core import scrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  input  logic [CrcW-1:0]  crc_init_i,
  input  logic [CrcW-1:0]  stored_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output scrc_res_t        res_o
);

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             in_run_q, in_run_d;
  logic [CrcW-1:0]  run_q, run_d;
  logic [CrcW-1:0]  crc_next;
  logic             adv;

  assign crc_next = crc_byte(in_run_q ? run_q : crc_init_i, in_byte_q);
  assign adv      = in_vld_q & (~in_last_q | res_ready_i);

  assign in_ready_o  = ~in_vld_q | adv;
  assign res_valid_o = in_vld_q & in_last_q;

  always_comb begin
    res_o.crc = crc_next;
    if (stored_i == EmptyStored) begin
      res_o.verdict = VERDICT_EMPTY;
    end else if (stored_i != crc_next) begin
      res_o.verdict = VERDICT_MISMATCH;
    end else begin
      res_o.verdict = VERDICT_MATCH;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    in_run_d = in_run_q;
    run_d    = run_q;
    if (adv) begin
      in_vld_d = 1'b0;
      in_run_d = ~in_last_q;
      run_d    = crc_next;
    end
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      in_run_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      in_run_q <= in_run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

endmodule

// ===== src/scrc_out.sv =====
`timescale 1ns / 1ps
// scrc_out: result register toward the master stream side
// depends on scrc_pkg
module scrc_out import scrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  output logic      res_ready_o,
  input  scrc_res_t res_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output scrc_res_t out_o
);

  logic      vld_q, vld_d;
  scrc_res_t res_q;

  assign res_ready_o = ~vld_q | out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = res_q;

  always_comb begin
    vld_d = vld_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (res_valid_i && res_ready_o) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

endmodule
